### hdl/ifk_pkg.sv
// Package: shared constants, codes and types for the IPv6 flow key extractor.
`default_nettype none
package ifk_pkg;

  localparam int MaxPacketBytes = 65535;
  localparam int PosW = $clog2(MaxPacketBytes + 1);
  localparam int HdrW = ((PosW > 11) ? PosW : 11) + 1;

  localparam int FhoW = 11;
  localparam int NfpW = 10;
  localparam int PaddrW = 4;
  localparam int PdataW = 32;

  localparam logic [1:0] RegFirstHdrOffset = 2'd0;
  localparam logic [1:0] RegNextFieldPos = 2'd1;
  localparam logic [1:0] RegMobilityEnable = 2'd2;

  localparam logic [FhoW-1:0] FhoReset = FhoW'(40);
  localparam logic [NfpW-1:0] NfpReset = NfpW'(6);

  localparam logic [7:0] ProtoHopByHop = 8'd0;
  localparam logic [7:0] ProtoTcp = 8'd6;
  localparam logic [7:0] ProtoUdp = 8'd17;
  localparam logic [7:0] ProtoDccp = 8'd33;
  localparam logic [7:0] ProtoRouting = 8'd43;
  localparam logic [7:0] ProtoIcmpv6 = 8'd58;
  localparam logic [7:0] ProtoDestOpts = 8'd60;
  localparam logic [7:0] ProtoSctp = 8'd132;
  localparam logic [7:0] ProtoMobility = 8'd135;
  localparam logic [7:0] ProtoUdpLite = 8'd136;

  localparam int SrcAddrFirst = 8;
  localparam int SrcAddrMid = 16;
  localparam int DstAddrFirst = 24;
  localparam int DstAddrMid = 32;
  localparam int AddrEnd = 40;

  typedef enum logic [1:0] {
    PH_WALK,
    PH_EXTLEN,
    PH_COLLECT,
    PH_DONE
  } ifk_phase_e;

  typedef struct packed {
    logic [FhoW-1:0] first_header_offset;
    logic [NfpW-1:0] next_field_position;
    logic            mobility_enable;
  } ifk_cfg_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] data_byte;
    logic       last_byte;
  } ifk_word_t;

  typedef struct packed {
    logic [63:0] dst_addr_hi;
    logic [63:0] dst_addr_lo;
    logic [63:0] src_addr_hi;
    logic [63:0] src_addr_lo;
    logic [7:0]  protocol;
    logic        found;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [7:0]  icmp_type;
    logic [7:0]  icmp_code;
    logic [7:0]  mobility_type;
  } ifk_key_t;

  function automatic logic is_ext_hdr(input logic [7:0] p);
    return (p == ProtoHopByHop) || (p == ProtoRouting) || (p == ProtoDestOpts);
  endfunction

  function automatic logic is_port_proto(input logic [7:0] p);
    return (p == ProtoTcp) || (p == ProtoUdp) || (p == ProtoUdpLite) ||
           (p == ProtoSctp) || (p == ProtoDccp);
  endfunction

endpackage
`default_nettype wire

### hdl/ifk_in_if.sv
// Interface: packet byte channel with valid/ready handshake.
`default_nettype none
interface ifk_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface
`default_nettype wire

### hdl/ifk_out_if.sv
// Interface: flow key channel with valid/ready handshake.
`default_nettype none
interface ifk_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] dst_addr_hi;
  logic [63:0] dst_addr_lo;
  logic [63:0] src_addr_hi;
  logic [63:0] src_addr_lo;
  logic [7:0]  protocol;
  logic        found;
  logic [15:0] src_port;
  logic [15:0] dst_port;
  logic [7:0]  icmp_type;
  logic [7:0]  icmp_code;
  logic [7:0]  mobility_type;

  modport source (
    output valid, input ready,
    output dst_addr_hi, output dst_addr_lo, output src_addr_hi, output src_addr_lo,
    output protocol, output found, output src_port, output dst_port,
    output icmp_type, output icmp_code, output mobility_type
  );
  modport sink (
    input valid, output ready,
    input dst_addr_hi, input dst_addr_lo, input src_addr_hi, input src_addr_lo,
    input protocol, input found, input src_port, input dst_port,
    input icmp_type, input icmp_code, input mobility_type
  );
endinterface
`default_nettype wire

### hdl/ipv6_flow_key_extractor.sv
// Top level: IPv6 flow key extractor with APB configuration.
// Takes one packet byte per cycle (one word per clock while in_i.ready is high) and
// presents one flow key per packet from the result register. Each byte
// passes an input register, then the walker updates the packet state and, on the
// last byte, loads the key into the result register. in_i.ready drops only while
// a last byte waits in the input register and the previous key has not been taken.
// Configuration is at byte addresses 0 (first header offset), 4 (next-header field
// position) and 8 (mobility enable).
`default_nettype none
module ipv6_flow_key_extractor
  import ifk_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  ifk_in_if.sink                 in_i,
  ifk_out_if.source              out_o,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [PaddrW-1:0] paddr,
  input  wire logic [PdataW-1:0] pwdata,
  output logic      [PdataW-1:0] prdata,
  output logic                   pready
);

  ifk_cfg_t  cfg;
  ifk_word_t word;
  logic      take;

  ifk_cfg_regs u_cfg_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  ifk_in_stage u_in_stage (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .take_i (take),
    .word_o (word)
  );

  ifk_walker u_walker (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .word_i (word),
    .take_o (take),
    .out_o  (out_o)
  );

endmodule
`default_nettype wire

### hdl/ifk_cfg_regs.sv
// Module: APB configuration registers of the flow key extractor.
`default_nettype none
module ifk_cfg_regs
  import ifk_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [PaddrW-1:0] paddr,
  input  wire logic [PdataW-1:0] pwdata,
  output logic      [PdataW-1:0] prdata,
  output logic                   pready,
  output ifk_cfg_t               cfg_o
);

  logic [FhoW-1:0] fho_q;
  logic [NfpW-1:0] nfp_q;
  logic            mob_q;
  logic            wr_en;
  logic [1:0]      reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fho_q <= FhoReset;
      nfp_q <= NfpReset;
      mob_q <= 1'b1;
    end else if (wr_en) begin
      unique case (reg_idx)
        RegFirstHdrOffset: fho_q <= pwdata[FhoW-1:0];
        RegNextFieldPos:   nfp_q <= pwdata[NfpW-1:0];
        RegMobilityEnable: mob_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      RegFirstHdrOffset: prdata = PdataW'(fho_q);
      RegNextFieldPos:   prdata = PdataW'(nfp_q);
      RegMobilityEnable: prdata = PdataW'(mob_q);
      default:           prdata = '0;
    endcase
  end

  assign cfg_o.first_header_offset = fho_q;
  assign cfg_o.next_field_position = nfp_q;
  assign cfg_o.mobility_enable     = mob_q;

endmodule
`default_nettype wire

### hdl/ifk_in_stage.sv
// Module: input register that holds one packet byte ahead of the walker.
`default_nettype none
module ifk_in_stage
  import ifk_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  ifk_in_if.sink     in_i,
  input  wire logic  take_i,
  output ifk_word_t  word_o
);

  logic       valid_q;
  logic [7:0] data_q;
  logic       last_q;
  logic       load;

  assign in_i.ready = !valid_q || take_i;
  assign load       = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= 1'b1;
    end else if (take_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= in_i.data_byte;
      last_q <= in_i.last_byte;
    end
  end

  assign word_o.valid     = valid_q;
  assign word_o.data_byte = data_q;
  assign word_o.last_byte = last_q;

endmodule
`default_nettype wire

### hdl/ifk_walker.sv
// Module: per-byte header walk, address capture and flow key result register.
`default_nettype none
module ifk_walker
  import ifk_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire ifk_cfg_t  cfg_i,
  input  wire ifk_word_t word_i,
  output logic           take_o,
  ifk_out_if.source      out_o
);

  logic [PosW-1:0] pos_q, pos_d;
  logic [7:0]      np_q, np_d;
  logic [HdrW-1:0] hs_q, hs_d;
  ifk_phase_e      phase_q, phase_d;
  logic [63:0]     src_hi_q, src_hi_d, src_lo_q, src_lo_d;
  logic [63:0]     dst_hi_q, dst_hi_d, dst_lo_q, dst_lo_d;
  logic [31:0]     tb_q, tb_d;
  logic            found_q, found_d;

  logic            out_valid_q;
  ifk_key_t        key_q, key_d;

  logic            out_free;
  logic            emit;
  logic            active;
  logic [HdrW-1:0] pos_w;
  logic [HdrW-1:0] hs_cur;
  logic [HdrW-1:0] k_off;
  logic [HdrW:0]   count;
  logic [HdrW:0]   hs_ext;
  logic [7:0]      b;
  logic [7:0]      np_mid;

  assign out_free = !out_valid_q || out_o.ready;
  assign take_o   = word_i.valid && (!word_i.last_byte || out_free);
  assign emit     = take_o && word_i.last_byte;
  assign b        = word_i.data_byte;

  always_comb begin
    active = (pos_q != PosW'(MaxPacketBytes));
    pos_w  = HdrW'(pos_q);
    hs_cur = (pos_q == '0) ? HdrW'(cfg_i.first_header_offset) : hs_q;
    k_off  = pos_w - hs_cur;
    np_mid = ((pos_w == HdrW'(cfg_i.next_field_position)) &&
              (pos_w < HdrW'(cfg_i.first_header_offset))) ? b : np_q;

    pos_d    = pos_q;
    np_d     = np_q;
    hs_d     = hs_q;
    phase_d  = phase_q;
    src_hi_d = src_hi_q;
    src_lo_d = src_lo_q;
    dst_hi_d = dst_hi_q;
    dst_lo_d = dst_lo_q;
    tb_d     = tb_q;
    found_d  = found_q;

    if (active) begin
      pos_d = pos_q + PosW'(1);
      hs_d  = hs_cur;
      np_d  = np_mid;
      if (pos_w >= HdrW'(SrcAddrFirst) && pos_w < HdrW'(SrcAddrMid)) begin
        src_hi_d = {src_hi_q[55:0], b};
      end else if (pos_w >= HdrW'(SrcAddrMid) && pos_w < HdrW'(DstAddrFirst)) begin
        src_lo_d = {src_lo_q[55:0], b};
      end else if (pos_w >= HdrW'(DstAddrFirst) && pos_w < HdrW'(DstAddrMid)) begin
        dst_hi_d = {dst_hi_q[55:0], b};
      end else if (pos_w >= HdrW'(DstAddrMid) && pos_w < HdrW'(AddrEnd)) begin
        dst_lo_d = {dst_lo_q[55:0], b};
      end

      unique case (phase_q)
        PH_WALK: begin
          if (pos_w == hs_cur) begin
            if (is_ext_hdr(np_mid)) begin
              np_d    = b;
              phase_d = PH_EXTLEN;
            end else if (is_port_proto(np_mid) || np_mid == ProtoIcmpv6 ||
                         (np_mid == ProtoMobility && cfg_i.mobility_enable)) begin
              found_d = 1'b1;
              phase_d = PH_COLLECT;
              tb_d    = {b, 24'h0};
            end else begin
              found_d = 1'b1;
              phase_d = PH_DONE;
            end
          end
        end
        PH_EXTLEN: begin
          if (pos_w == hs_cur + HdrW'(1)) begin
            hs_d    = hs_cur + HdrW'({b, 3'b000}) + HdrW'(8);
            phase_d = PH_WALK;
          end
        end
        PH_COLLECT: begin
          if (pos_w >= hs_cur) begin
            unique case (k_off)
              HdrW'(1): tb_d[23:16] = b;
              HdrW'(2): tb_d[15:8]  = b;
              HdrW'(3): tb_d[7:0]   = b;
              default: ;
            endcase
          end
        end
        PH_DONE: ;
        default: ;
      endcase
    end

    count  = active ? ((HdrW + 1)'(pos_q) + (HdrW + 1)'(1)) : (HdrW + 1)'(MaxPacketBytes);
    hs_ext = (HdrW + 1)'(hs_d);

    key_d             = '0;
    key_d.dst_addr_hi = dst_hi_d;
    key_d.dst_addr_lo = dst_lo_d;
    key_d.src_addr_hi = src_hi_d;
    key_d.src_addr_lo = src_lo_d;
    if (found_d) begin
      key_d.protocol = np_d;
      key_d.found    = 1'b1;
      if (phase_d == PH_COLLECT) begin
        if (is_port_proto(np_d)) begin
          if (count >= hs_ext + (HdrW + 1)'(4)) begin
            key_d.src_port = tb_d[31:16];
            key_d.dst_port = tb_d[15:0];
          end
        end else if (np_d == ProtoIcmpv6) begin
          if (count >= hs_ext + (HdrW + 1)'(2)) begin
            key_d.icmp_type = tb_d[31:24];
            key_d.icmp_code = tb_d[23:16];
          end
        end else if (np_d == ProtoMobility) begin
          if (count >= hs_ext + (HdrW + 1)'(3)) begin
            key_d.mobility_type = tb_d[15:8];
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      np_q     <= '0;
      hs_q     <= '0;
      phase_q  <= PH_WALK;
      src_hi_q <= '0;
      src_lo_q <= '0;
      dst_hi_q <= '0;
      dst_lo_q <= '0;
      tb_q     <= '0;
      found_q  <= 1'b0;
    end else if (emit) begin
      pos_q    <= '0;
      np_q     <= '0;
      hs_q     <= '0;
      phase_q  <= PH_WALK;
      src_hi_q <= '0;
      src_lo_q <= '0;
      dst_hi_q <= '0;
      dst_lo_q <= '0;
      tb_q     <= '0;
      found_q  <= 1'b0;
    end else if (take_o) begin
      pos_q    <= pos_d;
      np_q     <= np_d;
      hs_q     <= hs_d;
      phase_q  <= phase_d;
      src_hi_q <= src_hi_d;
      src_lo_q <= src_lo_d;
      dst_hi_q <= dst_hi_d;
      dst_lo_q <= dst_lo_d;
      tb_q     <= tb_d;
      found_q  <= found_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      key_q <= key_d;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.dst_addr_hi   = key_q.dst_addr_hi;
  assign out_o.dst_addr_lo   = key_q.dst_addr_lo;
  assign out_o.src_addr_hi   = key_q.src_addr_hi;
  assign out_o.src_addr_lo   = key_q.src_addr_lo;
  assign out_o.protocol      = key_q.protocol;
  assign out_o.found         = key_q.found;
  assign out_o.src_port      = key_q.src_port;
  assign out_o.dst_port      = key_q.dst_port;
  assign out_o.icmp_type     = key_q.icmp_type;
  assign out_o.icmp_code     = key_q.icmp_code;
  assign out_o.mobility_type = key_q.mobility_type;

  a_found_with_end_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_COLLECT || phase_q == PH_DONE) |-> found_q)
    else $error("walk ended without found flag");

  a_found_past_header: assert property (@(posedge clk_i) disable iff (!rst_ni)
    found_q |-> (HdrW'(pos_q) > hs_q))
    else $error("found flag set before header start was reached");

  a_emit_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> (pos_q == '0 && !found_q && phase_q == PH_WALK))
    else $error("packet state not cleared after last byte");

  a_emit_shows_key: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> out_valid_q)
    else $error("flow key not presented after last byte");

endmodule
`default_nettype wire
